/* rtl/core/vector2_alu_assert.svh */
// Assertion macros for the vector unit. The module that uses them provides clk and rst_n.
`ifndef VECTOR2_ALU_ASSERT_SVH
`define VECTOR2_ALU_ASSERT_SVH
`ifndef ASSERT_OFF
`define V2A_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("vector2_alu: assertion failed");
`define V2A_ASSERT_NEXT(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("vector2_alu: assertion failed");
`else
`define V2A_ASSERT(lbl, prop)
`define V2A_ASSERT_NEXT(lbl, pre, post)
`endif
`endif

/* rtl/core/vec2a_pkg.sv */
`default_nettype none
package vec2a_pkg;

    localparam logic [3:0] OP_ADD   = 4'd0;
    localparam logic [3:0] OP_SUB   = 4'd1;
    localparam logic [3:0] OP_SCALE = 4'd2;
    localparam logic [3:0] OP_DIV   = 4'd3;
    localparam logic [3:0] OP_LEN   = 4'd4;
    localparam logic [3:0] OP_SQLEN = 4'd5;
    localparam logic [3:0] OP_NORM  = 4'd6;
    localparam logic [3:0] OP_LERP  = 4'd7;
    localparam logic [3:0] OP_EQ    = 4'd8;

    localparam int SQRT_STAGES = 32;
    localparam int ROOT_W      = 32;
    localparam int DIV_STAGES  = 48;
    localparam int NUM_W       = 48;
    localparam int DEN_W       = 32;
    localparam int PRE_W       = 49;

    typedef struct packed {
        logic [3:0]              op;
        logic signed [PRE_W-1:0] pre_x;
        logic signed [PRE_W-1:0] pre_y;
        logic [NUM_W-1:0]        num_x;
        logic [NUM_W-1:0]        num_y;
        logic                    neg_x;
        logic                    neg_y;
        logic [DEN_W-1:0]        s_mag;
        logic                    s_zero;
        logic                    eq;
        logic [63:0]             sq;
    } front_t;

    typedef struct packed {
        logic [3:0]              op;
        logic signed [PRE_W-1:0] pre_x;
        logic signed [PRE_W-1:0] pre_y;
        logic                    neg_x;
        logic                    neg_y;
        logic                    s_zero;
        logic                    eq;
        logic [ROOT_W-1:0]       len;
        logic [47:0]             sq_hi;
    } back_t;

endpackage
`default_nettype wire

/* rtl/core/vec2a_front.sv */
`default_nettype none
module vec2a_front (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                adv,
    input  wire logic                in_valid,
    input  wire logic [3:0]          op,
    input  wire logic signed [31:0]  ax,
    input  wire logic signed [31:0]  ay,
    input  wire logic signed [31:0]  bx,
    input  wire logic signed [31:0]  by,
    input  wire logic signed [31:0]  s,
    output logic                     out_valid,
    output vec2a_pkg::front_t        front
);
    import vec2a_pkg::*;

    // Stage one: products.
    logic               v1_reg;
    logic [3:0]         op_reg;
    logic signed [31:0] ax_reg, ay_reg, bx_reg, by_reg, s_reg;
    logic signed [65:0] p1x_reg, p1y_reg, p1x_next, p1y_next;
    logic signed [63:0] p2x_reg, p2y_reg, p2x_next, p2y_next;
    logic signed [32:0] m1x, m1y;

    always_comb
    begin
        case (op)
            OP_SCALE:
            begin
                m1x = {s[31], s};
                m1y = {s[31], s};
            end
            OP_LEN, OP_SQLEN, OP_NORM:
            begin
                m1x = {ax[31], ax};
                m1y = {ay[31], ay};
            end
            default:
            begin
                m1x = 33'sd65536 - {s[31], s};
                m1y = 33'sd65536 - {s[31], s};
            end
        endcase
        p1x_next = $signed({ax[31], ax}) * m1x;
        p1y_next = $signed({ay[31], ay}) * m1y;
        p2x_next = bx * s;
        p2y_next = by * s;
    end

    // Stage two: sums, shifts and divider operands.
    logic               v2_reg;
    front_t             front_reg, front_next;
    logic signed [65:0] lsum_x, lsum_y, sh_x, sh_y, ls_x, ls_y;
    logic [31:0]        mag_ax, mag_ay, mag_s;
    logic               s_ge_one, s_le_zero;

    always_comb
    begin
        lsum_x    = p1x_reg + $signed({{2{p2x_reg[63]}}, p2x_reg});
        lsum_y    = p1y_reg + $signed({{2{p2y_reg[63]}}, p2y_reg});
        ls_x      = lsum_x >>> 16;
        ls_y      = lsum_y >>> 16;
        sh_x      = p1x_reg >>> 16;
        sh_y      = p1y_reg >>> 16;
        mag_ax    = ax_reg[31] ? (~ax_reg + 32'd1) : ax_reg;
        mag_ay    = ay_reg[31] ? (~ay_reg + 32'd1) : ay_reg;
        mag_s     = s_reg[31] ? (~s_reg + 32'd1) : s_reg;
        s_ge_one  = s_reg >= 32'sd65536;
        s_le_zero = s_reg[31] || (s_reg == 32'sd0);

        front_next        = '0;
        front_next.op     = op_reg;
        front_next.num_x  = {mag_ax, 16'd0};
        front_next.num_y  = {mag_ay, 16'd0};
        front_next.neg_x  = ax_reg[31] ^ ((op_reg == OP_DIV) && s_reg[31]);
        front_next.neg_y  = ay_reg[31] ^ ((op_reg == OP_DIV) && s_reg[31]);
        front_next.s_mag  = mag_s;
        front_next.s_zero = s_reg == 32'sd0;
        front_next.eq     = (ax_reg == bx_reg) && (ay_reg == by_reg);
        front_next.sq     = p1x_reg[63:0] + p1y_reg[63:0];
        case (op_reg)
            OP_ADD:
            begin
                front_next.pre_x = PRE_W'($signed({ax_reg[31], ax_reg}) + $signed({bx_reg[31], bx_reg}));
                front_next.pre_y = PRE_W'($signed({ay_reg[31], ay_reg}) + $signed({by_reg[31], by_reg}));
            end
            OP_SUB:
            begin
                front_next.pre_x = PRE_W'($signed({ax_reg[31], ax_reg}) - $signed({bx_reg[31], bx_reg}));
                front_next.pre_y = PRE_W'($signed({ay_reg[31], ay_reg}) - $signed({by_reg[31], by_reg}));
            end
            OP_SCALE:
            begin
                front_next.pre_x = sh_x[PRE_W-1:0];
                front_next.pre_y = sh_y[PRE_W-1:0];
            end
            OP_LERP:
            begin
                if (s_ge_one)
                begin
                    front_next.pre_x = {{(PRE_W-32){bx_reg[31]}}, bx_reg};
                    front_next.pre_y = {{(PRE_W-32){by_reg[31]}}, by_reg};
                end
                else if (s_le_zero)
                begin
                    front_next.pre_x = {{(PRE_W-32){ax_reg[31]}}, ax_reg};
                    front_next.pre_y = {{(PRE_W-32){ay_reg[31]}}, ay_reg};
                end
                else
                begin
                    front_next.pre_x = ls_x[PRE_W-1:0];
                    front_next.pre_y = ls_y[PRE_W-1:0];
                end
            end
            default:
            begin
                front_next.pre_x = '0;
                front_next.pre_y = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            op_reg    <= op;
            ax_reg    <= ax;
            ay_reg    <= ay;
            bx_reg    <= bx;
            by_reg    <= by;
            s_reg     <= s;
            p1x_reg   <= p1x_next;
            p1y_reg   <= p1y_next;
            p2x_reg   <= p2x_next;
            p2y_reg   <= p2y_next;
            front_reg <= front_next;
        end
    end

    assign out_valid = v2_reg;
    assign front     = front_reg;
endmodule
`default_nettype wire

/* rtl/core/vec2a_sqrt.sv */
`default_nettype none
module vec2a_sqrt (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       adv,
    input  wire logic                       in_valid,
    input  wire vec2a_pkg::front_t          in_side,
    output logic                            out_valid,
    output vec2a_pkg::front_t               out_side,
    output logic [vec2a_pkg::ROOT_W-1:0]    root
);
    import vec2a_pkg::*;

    // One root bit per stage, digit by digit from the top pair of bits.
    logic [34:0]       rem_reg  [SQRT_STAGES];
    logic [ROOT_W-1:0] root_reg [SQRT_STAGES];
    logic [63:0]       n_reg    [SQRT_STAGES];
    front_t            side_reg [SQRT_STAGES];
    logic              v_reg    [SQRT_STAGES];

    for (genvar i = 0; i < SQRT_STAGES; i++)
    begin : g_stage
        logic [34:0]       rem_prev, r_in, trial, rem_next;
        logic [ROOT_W-1:0] root_prev, root_next;
        logic [63:0]       n_prev;
        front_t            side_prev;
        logic              v_prev;

        if (i == 0)
        begin : g_first
            assign rem_prev  = '0;
            assign root_prev = '0;
            assign n_prev    = in_side.sq;
            assign side_prev = in_side;
            assign v_prev    = in_valid;
        end
        else
        begin : g_rest
            assign rem_prev  = rem_reg[i-1];
            assign root_prev = root_reg[i-1];
            assign n_prev    = n_reg[i-1];
            assign side_prev = side_reg[i-1];
            assign v_prev    = v_reg[i-1];
        end

        always_comb
        begin
            r_in  = {rem_prev[32:0], n_prev[63:62]};
            trial = {1'b0, root_prev, 2'b01};
            if (r_in >= trial)
            begin
                rem_next  = r_in - trial;
                root_next = {root_prev[ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = r_in;
                root_next = {root_prev[ROOT_W-2:0], 1'b0};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[i] <= 1'b0;
            end
            else if (adv)
            begin
                v_reg[i] <= v_prev;
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rem_reg[i]  <= rem_next;
                root_reg[i] <= root_next;
                n_reg[i]    <= {n_prev[61:0], 2'b00};
                side_reg[i] <= side_prev;
            end
        end
    end

    assign out_valid = v_reg[SQRT_STAGES-1];
    assign out_side  = side_reg[SQRT_STAGES-1];
    assign root      = root_reg[SQRT_STAGES-1];
endmodule
`default_nettype wire

/* rtl/core/vec2a_div.sv */
`default_nettype none
module vec2a_div (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       adv,
    input  wire logic                       in_valid,
    input  wire logic [vec2a_pkg::NUM_W-1:0] num_x,
    input  wire logic [vec2a_pkg::NUM_W-1:0] num_y,
    input  wire logic [vec2a_pkg::DEN_W-1:0] den,
    input  wire vec2a_pkg::back_t           in_side,
    output logic                            out_valid,
    output logic [vec2a_pkg::NUM_W-1:0]     q_x,
    output logic [vec2a_pkg::NUM_W-1:0]     q_y,
    output vec2a_pkg::back_t                out_side
);
    import vec2a_pkg::*;

    // Restoring division, one quotient bit per stage for both lanes. The dividend
    // shifts out of the top of nx_reg and ny_reg while quotient bits enter at the bottom.
    logic [DEN_W-1:0] rx_reg  [DIV_STAGES];
    logic [DEN_W-1:0] ry_reg  [DIV_STAGES];
    logic [NUM_W-1:0] nx_reg  [DIV_STAGES];
    logic [NUM_W-1:0] ny_reg  [DIV_STAGES];
    logic [DEN_W-1:0] d_reg   [DIV_STAGES];
    back_t            side_reg[DIV_STAGES];
    logic             v_reg   [DIV_STAGES];

    for (genvar i = 0; i < DIV_STAGES; i++)
    begin : g_stage
        logic [DEN_W-1:0] rx_prev, ry_prev, d_prev, rx_next, ry_next;
        logic [NUM_W-1:0] nx_prev, ny_prev;
        logic [DEN_W:0]   tx, ty;
        logic             bx, by;
        back_t            side_prev;
        logic             v_prev;

        if (i == 0)
        begin : g_first
            assign rx_prev   = '0;
            assign ry_prev   = '0;
            assign nx_prev   = num_x;
            assign ny_prev   = num_y;
            assign d_prev    = den;
            assign side_prev = in_side;
            assign v_prev    = in_valid;
        end
        else
        begin : g_rest
            assign rx_prev   = rx_reg[i-1];
            assign ry_prev   = ry_reg[i-1];
            assign nx_prev   = nx_reg[i-1];
            assign ny_prev   = ny_reg[i-1];
            assign d_prev    = d_reg[i-1];
            assign side_prev = side_reg[i-1];
            assign v_prev    = v_reg[i-1];
        end

        always_comb
        begin
            tx      = {rx_prev, nx_prev[NUM_W-1]};
            ty      = {ry_prev, ny_prev[NUM_W-1]};
            bx      = tx >= {1'b0, d_prev};
            by      = ty >= {1'b0, d_prev};
            rx_next = bx ? DEN_W'(tx - {1'b0, d_prev}) : tx[DEN_W-1:0];
            ry_next = by ? DEN_W'(ty - {1'b0, d_prev}) : ty[DEN_W-1:0];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[i] <= 1'b0;
            end
            else if (adv)
            begin
                v_reg[i] <= v_prev;
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rx_reg[i]   <= rx_next;
                ry_reg[i]   <= ry_next;
                nx_reg[i]   <= {nx_prev[NUM_W-2:0], bx};
                ny_reg[i]   <= {ny_prev[NUM_W-2:0], by};
                d_reg[i]    <= d_prev;
                side_reg[i] <= side_prev;
            end
        end
    end

    assign out_valid = v_reg[DIV_STAGES-1];
    assign q_x       = nx_reg[DIV_STAGES-1];
    assign q_y       = ny_reg[DIV_STAGES-1];
    assign out_side  = side_reg[DIV_STAGES-1];
endmodule
`default_nettype wire

/* rtl/core/vector2_alu.sv */
// Two-dimensional vector unit on signed Q16.16 operands: add, subtract, scale,
// divide by a scalar, length, squared length, normalize, linear interpolation and
// an equality compare. Every operation runs through the same 83-stage pipeline: two
// stages of multiplication and summing, 32 stages of square root (one root bit per
// stage) and 48 stages of division (one quotient bit per stage), then the output
// register. A beat is accepted in every cycle in which the output register is empty
// or being taken, so the sustained rate is one beat per clock while the output is
// not stalled. A stall at the output holds the whole pipeline in place. Results
// are clamped to the Q16.16 range and flag saturated.
`default_nettype none
`include "vector2_alu_assert.svh"
module vector2_alu (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // s_tdata from bit 0: opcode[3:0], a_x[35:4], a_y[67:36], b_x[99:68],
    // b_y[131:100], scalar[163:132], zero fill[167:164].
    input  wire logic [167:0] s_tdata,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // m_tdata from bit 0: res_x[31:0], res_y[63:32], is_equal[64], zero_guard[65],
    // saturated[66], zero fill[71:67].
    output logic [71:0]       m_tdata
);
    import vec2a_pkg::*;

    typedef struct packed {
        logic [31:0] val;
        logic        sat;
    } clamp_t;

    // Clamp to signed 32 bits: in range when all bits from 31 up agree.
    function automatic clamp_t clamp32(input logic [PRE_W-1:0] v);
        clamp_t c;
        if ((&v[PRE_W-1:31]) || !(|v[PRE_W-1:31]))
        begin
            c.val = v[31:0];
            c.sat = 1'b0;
        end
        else
        begin
            c.val = v[PRE_W-1] ? 32'h8000_0000 : 32'h7FFF_FFFF;
            c.sat = 1'b1;
        end
        return c;
    endfunction

    // The whole pipeline moves together whenever the output register can take a beat.
    logic adv;
    assign adv      = !m_tvalid || m_tready;
    assign s_tready = adv;

    logic   front_valid, sqrt_valid, div_valid;
    front_t front, sqrt_side;
    back_t  back_in, back_out;
    logic [ROOT_W-1:0] root;
    logic [NUM_W-1:0]  q_x, q_y;
    logic [DEN_W-1:0]  den;

    vec2a_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (s_tvalid),
        .op        (s_tdata[3:0]),
        .ax        (s_tdata[35:4]),
        .ay        (s_tdata[67:36]),
        .bx        (s_tdata[99:68]),
        .by        (s_tdata[131:100]),
        .s         (s_tdata[163:132]),
        .out_valid (front_valid),
        .front     (front)
    );

    vec2a_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (front_valid),
        .in_side   (front),
        .out_valid (sqrt_valid),
        .out_side  (sqrt_side),
        .root      (root)
    );

    // Normalize divides by the length, divide by the magnitude of the scalar.
    always_comb
    begin
        den            = (sqrt_side.op == OP_NORM) ? root : sqrt_side.s_mag;
        back_in.op     = sqrt_side.op;
        back_in.pre_x  = sqrt_side.pre_x;
        back_in.pre_y  = sqrt_side.pre_y;
        back_in.neg_x  = sqrt_side.neg_x;
        back_in.neg_y  = sqrt_side.neg_y;
        back_in.s_zero = sqrt_side.s_zero;
        back_in.eq     = sqrt_side.eq;
        back_in.len    = root;
        back_in.sq_hi  = sqrt_side.sq[63:16];
    end

    vec2a_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (sqrt_valid),
        .num_x     (sqrt_side.num_x),
        .num_y     (sqrt_side.num_y),
        .den       (den),
        .in_side   (back_in),
        .out_valid (div_valid),
        .q_x       (q_x),
        .q_y       (q_y),
        .out_side  (back_out)
    );

    // Final selection, sign restore and clamping into the output register.
    logic [PRE_W-1:0] sq_x, sq_y;
    clamp_t cx, cy;
    logic [31:0] rx_next, ry_next;
    logic        eq_next, zg_next, sat_next;

    always_comb
    begin
        sq_x     = back_out.neg_x ? PRE_W'(-{1'b0, q_x}) : {1'b0, q_x};
        sq_y     = back_out.neg_y ? PRE_W'(-{1'b0, q_y}) : {1'b0, q_y};
        rx_next  = '0;
        ry_next  = '0;
        eq_next  = 1'b0;
        zg_next  = 1'b0;
        sat_next = 1'b0;
        cx       = '0;
        cy       = '0;
        case (back_out.op)
            OP_ADD, OP_SUB, OP_SCALE, OP_LERP:
            begin
                cx       = clamp32(back_out.pre_x);
                cy       = clamp32(back_out.pre_y);
                rx_next  = cx.val;
                ry_next  = cy.val;
                sat_next = cx.sat || cy.sat;
            end
            OP_DIV, OP_NORM:
            begin
                if ((back_out.op == OP_DIV) ? back_out.s_zero : (back_out.len == '0))
                begin
                    zg_next = 1'b1;
                end
                else
                begin
                    cx       = clamp32(sq_x);
                    cy       = clamp32(sq_y);
                    rx_next  = cx.val;
                    ry_next  = cy.val;
                    sat_next = cx.sat || cy.sat;
                end
            end
            OP_LEN:
            begin
                sat_next = back_out.len[31];
                rx_next  = back_out.len[31] ? 32'h7FFF_FFFF : back_out.len;
            end
            OP_SQLEN:
            begin
                sat_next = |back_out.sq_hi[47:31];
                rx_next  = sat_next ? 32'h7FFF_FFFF : {1'b0, back_out.sq_hi[30:0]};
            end
            OP_EQ:
            begin
                eq_next = back_out.eq;
            end
            default:
            begin
                rx_next = '0;
            end
        endcase
    end

    logic        m_tvalid_reg;
    logic [31:0] res_x_reg, res_y_reg;
    logic        is_equal_reg, zero_guard_reg, saturated_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (adv)
        begin
            m_tvalid_reg <= div_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            res_x_reg      <= rx_next;
            res_y_reg      <= ry_next;
            is_equal_reg   <= eq_next;
            zero_guard_reg <= zg_next;
            saturated_reg  <= sat_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {5'd0, saturated_reg, zero_guard_reg, is_equal_reg, res_y_reg, res_x_reg};

    // A result carries at most one flag, and a guarded or compare result is zero.
    `V2A_ASSERT(a_flags_onehot0, !m_tvalid || $onehot0(m_tdata[66:64]))
    `V2A_ASSERT(a_guard_zero, (m_tvalid && m_tdata[65]) |-> (m_tdata[63:0] == 64'd0))
    `V2A_ASSERT(a_equal_zero, (m_tvalid && m_tdata[64]) |-> (m_tdata[63:0] == 64'd0))
    `V2A_ASSERT_NEXT(a_result_lands, div_valid && adv, m_tvalid)
endmodule
`default_nettype wire

/* verif/vector2_alu_test.sv */
`timescale 1ns / 100ps
`default_nettype none
module vector2_alu_test;
    import vec2a_pkg::*;

    // One input beat of the vector unit.
    typedef struct {
        logic [3:0]   op;
        logic [31:0]  ax;
        logic [31:0]  ay;
        logic [31:0]  bx;
        logic [31:0]  by;
        logic [31:0]  s;
    } vec_cmd_t;

    // One output beat.
    typedef struct {
        logic [31:0] rx;
        logic [31:0] ry;
        logic        eq;
        logic        zg;
        logic        sat;
    } vec_res_t;

    localparam int PIPE_LATENCY = 83;
    localparam longint Q_ONE    = 65536;
    localparam longint S32_MAX  = 64'sd2147483647;
    localparam longint S32_MIN  = -64'sd2147483648;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    // s_tdata fields from bit 0: opcode, a_x, a_y, b_x, b_y, scalar, zero fill.
    logic [167:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    // m_tdata fields from bit 0: res_x, res_y, is_equal, zero_guard, saturated, zero fill.
    logic [71:0]  m_tdata;

    vec_res_t     expected_results[$];
    int           mismatch_count;
    bit           sender_idle_en;
    bit           receiver_idle_en;

    vector2_alu u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // Clamp a wide value into the signed 32-bit range, noting any clamp.
    function automatic longint clamp_q16(input longint v, inout bit sat);
        if (v > S32_MAX)
        begin
            sat = 1'b1;
            return S32_MAX;
        end
        if (v < S32_MIN)
        begin
            sat = 1'b1;
            return S32_MIN;
        end
        return v;
    endfunction

    // Floor of a 64-bit unsigned square root, bit by bit.
    function automatic logic [63:0] floor_sqrt(input logic [63:0] n);
        logic [63:0] root;
        logic [63:0] bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > n)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (n >= root + bitv)
            begin
                n = n - (root + bitv);
                root = (root >> 1) + bitv;
            end
            else
                root = root >> 1;
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    // Computes the vector result that one command must produce.
    function automatic vec_res_t vector_result(input vec_cmd_t c);
        vec_res_t    r;
        longint      ax, ay, bx, by, s, rx, ry;
        longint      len;
        logic [63:0] mx, my, sq, root;
        bit          sat;
        ax = longint'($signed(c.ax));
        ay = longint'($signed(c.ay));
        bx = longint'($signed(c.bx));
        by = longint'($signed(c.by));
        s  = longint'($signed(c.s));
        rx = 0;
        ry = 0;
        sat = 1'b0;
        r.eq = 1'b0;
        r.zg = 1'b0;
        case (c.op)
            OP_ADD:
            begin
                rx = clamp_q16(ax + bx, sat);
                ry = clamp_q16(ay + by, sat);
            end
            OP_SUB:
            begin
                rx = clamp_q16(ax - bx, sat);
                ry = clamp_q16(ay - by, sat);
            end
            OP_SCALE:
            begin
                // Arithmetic shift is a floor division by 2^16.
                rx = clamp_q16((ax * s) >>> 16, sat);
                ry = clamp_q16((ay * s) >>> 16, sat);
            end
            OP_DIV:
            begin
                if (s == 0)
                    r.zg = 1'b1;
                else
                begin
                    rx = clamp_q16((ax * Q_ONE) / s, sat);
                    ry = clamp_q16((ay * Q_ONE) / s, sat);
                end
            end
            OP_LEN, OP_SQLEN, OP_NORM:
            begin
                mx = (ax < 0) ? -ax : ax;
                my = (ay < 0) ? -ay : ay;
                sq = mx * mx + my * my;
                if (c.op == OP_SQLEN)
                begin
                    sq = sq >> 16;
                    if (sq > 64'(S32_MAX))
                    begin
                        sat = 1'b1;
                        sq = 64'(S32_MAX);
                    end
                    rx = longint'(sq);
                end
                else
                begin
                    root = floor_sqrt(sq);
                    if (c.op == OP_LEN)
                    begin
                        if (root > 64'(S32_MAX))
                        begin
                            sat = 1'b1;
                            root = 64'(S32_MAX);
                        end
                        rx = longint'(root);
                    end
                    else if (root == 0)
                        r.zg = 1'b1;
                    else
                    begin
                        len = longint'(root);
                        rx = clamp_q16((ax * Q_ONE) / len, sat);
                        ry = clamp_q16((ay * Q_ONE) / len, sat);
                    end
                end
            end
            OP_LERP:
            begin
                if (s >= Q_ONE)
                begin
                    rx = bx;
                    ry = by;
                end
                else if (s <= 0)
                begin
                    rx = ax;
                    ry = ay;
                end
                else
                begin
                    rx = clamp_q16((ax * (Q_ONE - s) + bx * s) >>> 16, sat);
                    ry = clamp_q16((ay * (Q_ONE - s) + by * s) >>> 16, sat);
                end
            end
            OP_EQ:
                r.eq = (ax == bx) && (ay == by);
            default:
            begin
            end
        endcase
        r.rx = rx[31:0];
        r.ry = ry[31:0];
        r.sat = sat;
        return r;
    endfunction

    // Drives one command beat and records its expected result on acceptance.
    // Valid stays high between back-to-back beats and drops only for idling.
    task automatic send_cmd(input vec_cmd_t c);
        if (sender_idle_en && $urandom_range(0, 5) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge clk);
        end
        s_tdata  <= {4'd0, c.s, c.by, c.bx, c.ay, c.ax, c.op};
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        expected_results.push_back(vector_result(c));
        @(negedge clk);
    endtask

    // Receiver: randomly withholds ready and checks each accepted beat.
    always @(negedge clk)
    begin
        if (receiver_idle_en && $urandom_range(0, 4) == 0)
            m_tready <= 1'b0;
        else
            m_tready <= 1'b1;
    end

    always @(posedge clk)
    begin
        vec_res_t exp_r;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_results.size() == 0)
            begin
                $display("%0t: unexpected beat, actual %h", $time, m_tdata);
                mismatch_count++;
            end
            else
            begin
                exp_r = expected_results.pop_front();
                if (m_tdata[31:0] !== exp_r.rx || m_tdata[63:32] !== exp_r.ry
                    || m_tdata[64] !== exp_r.eq || m_tdata[65] !== exp_r.zg
                    || m_tdata[66] !== exp_r.sat)
                begin
                    $display("%0t: mismatch, expected x=%h y=%h eq=%b zg=%b sat=%b, actual %h",
                             $time, exp_r.rx, exp_r.ry, exp_r.eq, exp_r.zg, exp_r.sat,
                             m_tdata);
                    mismatch_count++;
                end
            end
        end
    end

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return 32'(signed'($urandom_range(0, 8 * 65536)) - 4 * 65536);
            2: return {$urandom_range(0, 1) ? 16'hFFFF : 16'h0000, 16'($urandom)};
            3: return 32'($urandom_range(0, 65536));
            4: return $urandom_range(0, 1) ? 32'h7FFFFFFF : 32'h80000000;
            default: return 32'(signed'($urandom_range(0, 200)) - 100) << 16;
        endcase
    endfunction

    // Drops valid and waits until every outstanding result has come back.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0)
            @(negedge clk);
    endtask

    // Extremes of every field and every named special case.
    task automatic test_directed();
        vec_cmd_t c;
        logic [31:0] ext[4];
        ext = '{32'h7FFFFFFF, 32'h80000000, 32'h00000000, 32'hFFFFFFFF};
        for (int k = 0; k <= 8; k++)
        begin
            c.op = 4'(k);
            c.ax = ext[k % 4];
            c.ay = ext[(k + 1) % 4];
            c.bx = ext[(k + 2) % 4];
            c.by = ext[(k + 3) % 4];
            c.s  = ext[k % 4];
            send_cmd(c);
        end
        // Division by zero and normalization of the zero vector.
        c = '{OP_DIV, 32'h00030000, 32'hFFFE0000, 0, 0, 0};
        send_cmd(c);
        c = '{OP_NORM, 0, 0, 1, 1, 1};
        send_cmd(c);
        // Lerp at weight 1, just under 1, and at 0.
        c = '{OP_LERP, 32'h00010000, 32'h00020000, 32'h00050000, 32'hFFFB0000, 32'h00010000};
        send_cmd(c);
        c.s = 32'h0000FFFF;
        send_cmd(c);
        c.s = 0;
        send_cmd(c);
        // Equal vectors, and unused opcodes.
        c = '{OP_EQ, 32'h12345678, 32'h9ABCDEF0, 32'h12345678, 32'h9ABCDEF0, 0};
        send_cmd(c);
        c = '{4'd9, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF};
        send_cmd(c);
        c.op = 4'd15;
        send_cmd(c);
        c = '{OP_LEN, 32'h80000000, 32'h80000000, 0, 0, 0};
        send_cmd(c);
        c.op = OP_SQLEN;
        send_cmd(c);
    endtask

    task automatic test_random(input int count);
        vec_cmd_t c;
        for (int i = 0; i < count; i++)
        begin
            c.op = ($urandom_range(0, 15) == 0) ? 4'($urandom_range(9, 15))
                                                : 4'($urandom_range(0, 8));
            c.ax = rand_word();
            c.ay = rand_word();
            c.bx = ($urandom_range(0, 3) == 0) ? c.ax : rand_word();
            c.by = ($urandom_range(0, 3) == 0) ? c.ay : rand_word();
            c.s  = ($urandom_range(0, 15) == 0) ? 32'd0 : rand_word();
            send_cmd(c);
        end
    endtask

    // The sender holds off until every outstanding result has come back.
    task automatic test_drain_pause();
        wait_drained();
        test_random(20);
    endtask

    initial
    begin
        mismatch_count = 0;
        sender_idle_en = 1'b1;
        receiver_idle_en = 1'b1;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        test_directed();
        test_random(900);
        test_drain_pause();
        // Last stretch runs at full rate with no idling on either side.
        sender_idle_en = 1'b0;
        receiver_idle_en = 1'b0;
        test_random(400);
        wait_drained();
        repeat (PIPE_LATENCY + 10) @(negedge clk);
        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
`default_nettype wire

/* filelist.f */
+incdir+rtl/core
rtl/core/vec2a_pkg.sv
rtl/core/vec2a_front.sv
rtl/core/vec2a_sqrt.sv
rtl/core/vec2a_div.sv
rtl/core/vector2_alu.sv
verif/vector2_alu_test.sv
